// ----- design/assert_macros.svh -----
// assertion macros used by the checker file mck_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked property, masked while reset is asserted
`define MCK_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// checked property that also holds through reset
`define MCK_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/mck_pkg.sv -----
// shared types, constants and symbol tables of the morse character keyer
// no dependencies
`default_nettype none

package mck_pkg;

  localparam int CHAR_W       = 8;
  localparam int DUR_W        = 16;
  localparam int PAT_W        = 5;
  localparam int LEN_W        = 3;
  localparam int CFG_IDX_W    = 4;
  localparam int SYMBOL_COUNT = 37;
  localparam int SYM_IDX_W    = $clog2(SYMBOL_COUNT);
  localparam int FIFO_DEPTH_DEF = 2;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_DOT_ON      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DASH_ON     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_GAP = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_LETTER_GAP  = CFG_IDX_W'(3);

  localparam logic [DUR_W-1:0] DOT_ON_RST      = DUR_W'(200);
  localparam logic [DUR_W-1:0] DASH_ON_RST     = DUR_W'(800);
  localparam logic [DUR_W-1:0] ELEMENT_GAP_RST = DUR_W'(400);
  localparam logic [DUR_W-1:0] LETTER_GAP_RST  = DUR_W'(600);

  localparam logic [SYM_IDX_W-1:0] DIGIT_BASE = SYM_IDX_W'(26);
  localparam logic [SYM_IDX_W-1:0] SPACE_IDX  = SYM_IDX_W'(36);

  // a..z, 0..9, space
  localparam logic [LEN_W-1:0] SYM_LEN [SYMBOL_COUNT] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
    3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4,
    3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5,
    3'd0
  };

  // right-aligned, 1 = dash, first element in the highest used bit
  localparam logic [PAT_W-1:0] SYM_PAT [SYMBOL_COUNT] = '{
    5'd1, 5'd8, 5'd10, 5'd4, 5'd0, 5'd2, 5'd6, 5'd0, 5'd0, 5'd7, 5'd5, 5'd4, 5'd3,
    5'd2, 5'd7, 5'd6, 5'd13, 5'd2, 5'd0, 5'd1, 5'd1, 5'd1, 5'd3, 5'd9, 5'd11, 5'd12,
    5'd31, 5'd15, 5'd7, 5'd3, 5'd1, 5'd0, 5'd16, 5'd24, 5'd28, 5'd30,
    5'd0
  };

  // queued symbol: pattern left-aligned so the next element sits in the msb
  typedef struct packed {
    logic [PAT_W-1:0] pattern;
    logic [LEN_W-1:0] len;
  } sym_entry_t;

  typedef struct packed {
    logic       valid;
    sym_entry_t entry;
  } sym_class_t;

  typedef struct packed {
    logic [DUR_W-1:0] dot_on;
    logic [DUR_W-1:0] dash_on;
    logic [DUR_W-1:0] element_gap;
    logic [DUR_W-1:0] letter_gap;
  } cfg_regs_t;

  function automatic sym_class_t classify(input logic [CHAR_W-1:0] ch);
    logic [SYM_IDX_W-1:0] idx;
    logic [LEN_W-1:0]     len;
    sym_class_t           res;
    idx       = '0;
    res.valid = 1'b1;
    if (ch >= 8'h61 && ch <= 8'h7a) begin
      idx = SYM_IDX_W'(ch - 8'h61);
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      idx = SYM_IDX_W'(ch - 8'h30) + DIGIT_BASE;
    end else if (ch == 8'h20) begin
      idx = SPACE_IDX;
    end else begin
      res.valid = 1'b0;
    end
    len = SYM_LEN[idx];
    res.entry.len     = len;
    res.entry.pattern = SYM_PAT[idx] << (LEN_W'(PAT_W) - len);
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- design/mck_front.sv -----
// front end: takes characters, drops unknown bytes, queues symbol codes
// depends on mck_pkg
`default_nettype none

module mck_front (
  input  wire logic                        in_valid,
  input  wire logic [mck_pkg::CHAR_W-1:0]  in_character,
  output logic                             in_stall,
  input  wire logic                        q_full,
  output logic                             q_push,
  output mck_pkg::sym_entry_t              q_wdata
);

  mck_pkg::sym_class_t cls;

  always_comb begin
    cls      = mck_pkg::classify(in_character);
    in_stall = q_full;
    // unknown bytes are taken and dropped
    q_push   = in_valid && !q_full && cls.valid;
    q_wdata  = cls.entry;
  end

endmodule

`default_nettype wire

// ----- design/mck_fifo.sv -----
// small symbol queue between front end and sequencer
// depends on mck_pkg
`default_nettype none

module mck_fifo #(
  parameter int DEPTH = mck_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire mck_pkg::sym_entry_t  wdata,
  output logic                      full,
  input  wire logic                 pop,
  output mck_pkg::sym_entry_t       rdata,
  output logic                      empty
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mck_pkg::sym_entry_t entries_r [DEPTH];
  logic [IDX_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [IDX_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  always_comb begin
    empty   = (count_r == '0);
    full    = (count_r == CNT_W'(DEPTH));
    rdata   = entries_r[rd_ptr_r];
    do_push = push && !full;
    do_pop  = pop && !empty;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ----- design/mck_back.sv -----
// sequencer: walks the queued symbol and emits one keying interval per cycle while out_stall is low
// depends on mck_pkg
`default_nettype none

module mck_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire mck_pkg::cfg_regs_t          cfg,
  input  wire logic                        q_empty,
  input  wire mck_pkg::sym_entry_t         q_rdata,
  output logic                             q_pop,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             out_led_on,
  output logic [mck_pkg::DUR_W-1:0]        out_duration_ms,
  output logic                             out_last
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_ON     = 4'b0010,
    ST_GAP    = 4'b0100,
    ST_LETTER = 4'b1000
  } seq_state_t;

  seq_state_t state_r, state_nxt;
  logic [mck_pkg::PAT_W-1:0] pat_r, pat_nxt;
  logic [mck_pkg::LEN_W-1:0] left_r, left_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic                      led_r, last_r;
  logic [mck_pkg::DUR_W-1:0] dur_r;
  logic                      can_emit, emit, emit_led, emit_last;
  logic [mck_pkg::DUR_W-1:0] emit_dur;

  always_comb begin
    can_emit  = !out_valid_r || !out_stall;
    state_nxt = state_r;
    pat_nxt   = pat_r;
    left_nxt  = left_r;
    q_pop     = 1'b0;
    emit      = 1'b0;
    emit_led  = 1'b0;
    emit_last = 1'b0;
    emit_dur  = cfg.letter_gap;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          pat_nxt   = q_rdata.pattern;
          left_nxt  = q_rdata.len;
          // a space has no elements, only the closing gap
          state_nxt = (q_rdata.len == '0) ? ST_LETTER : ST_ON;
        end
      end
      ST_ON: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_led  = 1'b1;
          emit_dur  = pat_r[mck_pkg::PAT_W-1] ? cfg.dash_on : cfg.dot_on;
          state_nxt = ST_GAP;
        end
      end
      ST_GAP: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_dur  = cfg.element_gap;
          pat_nxt   = pat_r << 1;
          left_nxt  = left_r - 1'b1;
          state_nxt = (left_r == mck_pkg::LEN_W'(1)) ? ST_LETTER : ST_ON;
        end
      end
      ST_LETTER: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_last = 1'b1;
          emit_dur  = cfg.letter_gap;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    out_valid_nxt = emit ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pat_r  <= pat_nxt;
    left_r <= left_nxt;
    if (emit) begin
      led_r  <= emit_led;
      dur_r  <= emit_dur;
      last_r <= emit_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_led_on      = led_r;
  assign out_duration_ms = dur_r;
  assign out_last        = last_r;

endmodule

`default_nettype wire

// ----- design/morse_character_keyer.sv -----
// top level of the morse character keyer: configuration registers and wiring
// depends on mck_pkg, mck_front, mck_fifo, mck_back
`default_nettype none

// Each accepted ASCII byte (a-z, 0-9, space) turns into a run of LED keying
// intervals on the out channel: for every dot or dash an on interval followed
// by an element gap, then one letter gap marked with out_last; a space gives
// only the letter gap and any other byte is accepted and gives nothing. A
// character with n elements yields 2n+1 intervals; the sequencer emits one
// interval per cycle while out_stall is low and loads the next symbol from the
// input queue in its idle state between characters. The input side keeps
// taking characters until the FIFO_DEPTH-entry queue fills. Durations come from
// the configuration registers as they stand when the interval is emitted, so
// write them only while the block is idle.
module morse_character_keyer #(
  parameter int FIFO_DEPTH = mck_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [mck_pkg::CHAR_W-1:0]    in_character,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_led_on,
  output logic [mck_pkg::DUR_W-1:0]          out_duration_ms,
  output logic                               out_last,
  input  wire logic                          cfg_we,
  input  wire logic [mck_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mck_pkg::DUR_W-1:0]     cfg_wdata
);

  mck_pkg::cfg_regs_t  cfg_r, cfg_nxt;
  mck_pkg::sym_entry_t q_wdata, q_rdata;
  logic                q_push, q_pop, q_full, q_empty;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        mck_pkg::REG_DOT_ON:      cfg_nxt.dot_on      = cfg_wdata;
        mck_pkg::REG_DASH_ON:     cfg_nxt.dash_on     = cfg_wdata;
        mck_pkg::REG_ELEMENT_GAP: cfg_nxt.element_gap = cfg_wdata;
        mck_pkg::REG_LETTER_GAP:  cfg_nxt.letter_gap  = cfg_wdata;
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dot_on      <= mck_pkg::DOT_ON_RST;
      cfg_r.dash_on     <= mck_pkg::DASH_ON_RST;
      cfg_r.element_gap <= mck_pkg::ELEMENT_GAP_RST;
      cfg_r.letter_gap  <= mck_pkg::LETTER_GAP_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  mck_front u_front (
    .in_valid     (in_valid),
    .in_character (in_character),
    .in_stall     (in_stall),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_wdata      (q_wdata)
  );

  mck_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  mck_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_empty         (q_empty),
    .q_rdata         (q_rdata),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_led_on      (out_led_on),
    .out_duration_ms (out_duration_ms),
    .out_last        (out_last)
  );

endmodule

`default_nettype wire

// ----- design/mck_checker.sv -----
// port-level checks of the morse character keyer, bound to the top level
// depends on mck_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module mck_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic [mck_pkg::CHAR_W-1:0]    in_character,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic                          out_led_on,
  input wire logic [mck_pkg::DUR_W-1:0]     out_duration_ms,
  input wire logic                          out_last
);

  // a stalled character request keeps its payload
  `MCK_ASSERT(a_in_hold, clk, rst_n, in_valid && in_stall |=> in_valid && $stable(in_character), "stalled request changed")

  // a stalled result keeps its request and payload
  `MCK_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_led_on) && $stable(out_duration_ms) && $stable(out_last), "stalled result changed")

  // the closing interval of a character is always dark
  `MCK_ASSERT(a_last_dark, clk, rst_n, out_valid && out_last |-> !out_led_on, "last interval has led on")

  // an on interval is always followed by a dark one
  `MCK_ASSERT(a_on_then_gap, clk, rst_n, out_valid && !out_stall && out_led_on |=> !(out_valid && out_led_on), "two on intervals in a row")

  // nothing is offered right after reset
  `MCK_ASSERT_RST(a_reset_idle, clk, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind morse_character_keyer mck_checker u_mck_checker (.*);

`default_nettype wire

// ----- tb/tb_morse_character_keyer.sv -----
// self-checking testbench for morse_character_keyer: directed table, then random characters
// across several timing settings, checked against an in-bench keying predictor
// depends on mck_pkg and the morse_character_keyer rtl
`default_nettype none

module tb_morse_character_keyer;
  timeunit 1ns;
  timeprecision 1ps;

  import mck_pkg::*;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 9;
  localparam int SETTLE_CYCLES = 40;
  localparam int WATCHDOG_MAX  = 1000;
  localparam int NUM_PHASES    = 8;
  localparam int PHASE_ITEMS   = 60;
  localparam int DUR_MAX       = (1 << DUR_W) - 1;
  localparam int CFG_IDX_MAX   = (1 << CFG_IDX_W) - 1;

  typedef struct packed {
    logic             led_on;
    logic [DUR_W-1:0] duration_ms;
    logic             last;
  } interval_t;

  // typed = 1: the row's intervals are listed here, typed_cnt of them (none for ignored bytes)
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              typed;
    logic [1:0]        typed_cnt;
    interval_t [0:2]   intervals;
  } char_row_t;

  localparam interval_t DOT_IV    = '{1'b1, DOT_ON_RST, 1'b0};
  localparam interval_t DASH_IV   = '{1'b1, DASH_ON_RST, 1'b0};
  localparam interval_t GAP_IV    = '{1'b0, ELEMENT_GAP_RST, 1'b0};
  localparam interval_t LETTER_IV = '{1'b0, LETTER_GAP_RST, 1'b1};
  localparam interval_t NO_IV     = '0;

  localparam int NUM_ROWS = 20;
  localparam char_row_t DIRECTED [NUM_ROWS] = '{
    '{8'h65, 1'b1, 2'd3, '{DOT_IV, GAP_IV, LETTER_IV}},   // e
    '{8'h74, 1'b1, 2'd3, '{DASH_IV, GAP_IV, LETTER_IV}},  // t
    '{8'h20, 1'b1, 2'd1, '{LETTER_IV, NO_IV, NO_IV}},     // space: letter gap only
    '{8'h00, 1'b1, 2'd0, '{NO_IV, NO_IV, NO_IV}},
    '{8'hff, 1'b1, 2'd0, '{NO_IV, NO_IV, NO_IV}},
    '{8'h41, 1'b1, 2'd0, '{NO_IV, NO_IV, NO_IV}},         // uppercase ignored
    '{8'h7f, 1'b1, 2'd0, '{NO_IV, NO_IV, NO_IV}},
    '{8'h2f, 1'b1, 2'd0, '{NO_IV, NO_IV, NO_IV}},         // just below '0'
    '{8'h3a, 1'b1, 2'd0, '{NO_IV, NO_IV, NO_IV}},         // just above '9'
    '{8'h60, 1'b1, 2'd0, '{NO_IV, NO_IV, NO_IV}},         // just below 'a'
    '{8'h7b, 1'b1, 2'd0, '{NO_IV, NO_IV, NO_IV}},         // just above 'z'
    '{8'h80, 1'b1, 2'd0, '{NO_IV, NO_IV, NO_IV}},
    '{8'h61, 1'b0, 2'd0, '0},
    '{8'h7a, 1'b0, 2'd0, '0},
    '{8'h30, 1'b0, 2'd0, '0},
    '{8'h39, 1'b0, 2'd0, '0},
    '{8'h35, 1'b0, 2'd0, '0},
    '{8'h68, 1'b0, 2'd0, '0},
    '{8'h71, 1'b0, 2'd0, '0},
    '{8'h6d, 1'b0, 2'd0, '0}
  };

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [CHAR_W-1:0]    in_character = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_led_on;
  logic [DUR_W-1:0]     out_duration_ms;
  logic                 out_last;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DUR_W-1:0]     cfg_wdata = '0;

  morse_character_keyer dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_character    (in_character),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_led_on      (out_led_on),
    .out_duration_ms (out_duration_ms),
    .out_last        (out_last),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  // timing registers as the block should hold them
  logic [DUR_W-1:0] dot_ms       = DOT_ON_RST;
  logic [DUR_W-1:0] dash_ms      = DASH_ON_RST;
  logic [DUR_W-1:0] elem_gap_ms  = ELEMENT_GAP_RST;
  logic [DUR_W-1:0] letter_gap_ms = LETTER_GAP_RST;

  interval_t intervals_due[$];
  int        mismatches = 0;
  bit        quiet_mode = 1'b0;

  initial begin
    forever #HALF_PERIOD clk = ~clk;
  end

  // dots and dashes of each recognized character, "?" for bytes the block ignores
  function automatic string morse_code(input logic [CHAR_W-1:0] ch);
    case (ch)
      "a": return ".-";    "b": return "-...";  "c": return "-.-.";  "d": return "-..";
      "e": return ".";     "f": return "..-.";  "g": return "--.";   "h": return "....";
      "i": return "..";    "j": return ".---";  "k": return "-.-";   "l": return ".-..";
      "m": return "--";    "n": return "-.";    "o": return "---";   "p": return ".--.";
      "q": return "--.-";  "r": return ".-.";   "s": return "...";   "t": return "-";
      "u": return "..-";   "v": return "...-";  "w": return ".--";   "x": return "-..-";
      "y": return "-.--";  "z": return "--..";
      "0": return "-----"; "1": return ".----"; "2": return "..---"; "3": return "...--";
      "4": return "....-"; "5": return "....."; "6": return "-...."; "7": return "--...";
      "8": return "---.."; "9": return "----.";
      " ": return "";
      default: return "?";
    endcase
  endfunction

  task automatic predict_intervals(input logic [CHAR_W-1:0] ch);
    string            code;
    logic [PAT_W-1:0] pat;
    logic [LEN_W-1:0] len;
    interval_t        iv;
    code = morse_code(ch);
    if (code == "?") return;
    pat = '0;
    len = LEN_W'(code.len());
    for (int i = 0; i < code.len(); i++) pat = {pat[PAT_W-2:0], code[i] == "-"};
    for (int e = 0; e < len; e++) begin
      iv.led_on      = 1'b1;
      iv.duration_ms = pat[len - 1 - e] ? dash_ms : dot_ms;
      iv.last        = 1'b0;
      intervals_due.push_back(iv);
      iv = '{1'b0, elem_gap_ms, 1'b0};
      intervals_due.push_back(iv);
    end
    iv = '{1'b0, letter_gap_ms, 1'b1};
    intervals_due.push_back(iv);
  endtask

  // mostly keyable characters, the rest any byte
  function automatic logic [CHAR_W-1:0] random_char();
    int pick;
    if ($urandom_range(0, 99) >= 85) return CHAR_W'($urandom_range(0, 255));
    pick = $urandom_range(0, 36);
    if (pick < 26) return CHAR_W'("a" + pick);
    if (pick < 36) return CHAR_W'("0" + pick - 26);
    return CHAR_W'(" ");
  endfunction

  function automatic logic [DUR_W-1:0] random_duration(input int low);
    case ($urandom_range(0, 3))
      0: return DUR_W'(low);
      1: return DUR_W'(DUR_MAX);
      default: return DUR_W'($urandom_range(low, DUR_MAX));
    endcase
  endfunction

  // called in the time step of a rising edge; returns in a later one
  task automatic send_char(input logic [CHAR_W-1:0] ch);
    in_valid     <= 1'b1;
    in_character <= ch;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    if (!quiet_mode && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DUR_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_DOT_ON:      dot_ms        = val;
      REG_DASH_ON:     dash_ms       = val;
      REG_ELEMENT_GAP: elem_gap_ms   = val;
      REG_LETTER_GAP:  letter_gap_ms = val;
      default: ;
    endcase
  endtask

  task automatic program_timing(input logic [DUR_W-1:0] dot, input logic [DUR_W-1:0] dash,
                                input logic [DUR_W-1:0] egap, input logic [DUR_W-1:0] lgap);
    write_reg(REG_DOT_ON, dot);
    write_reg(REG_DASH_ON, dash);
    write_reg(REG_ELEMENT_GAP, egap);
    write_reg(REG_LETTER_GAP, lgap);
    // an index past the register list must leave every register alone
    write_reg(CFG_IDX_W'($urandom_range(REG_LETTER_GAP + 1, CFG_IDX_MAX)),
              DUR_W'($urandom_range(0, DUR_MAX)));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // waits until every expected interval has arrived, then lets the block settle
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (intervals_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic void check_field(input string what, input int want, input int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endfunction

  // receiver: stall bursts and free runs of random length
  int burst_left = 0;
  bit stall_now  = 1'b0;
  always @(posedge clk) begin
    if (burst_left == 0) begin
      stall_now  = ($urandom_range(0, 2) == 0);
      burst_left = stall_now ? $urandom_range(1, 12) : $urandom_range(1, 30);
    end
    burst_left--;
    out_stall <= stall_now && !quiet_mode;
  end

  // inputs only change at rising edges, so the falling edge shows what the next edge takes
  interval_t want_iv;
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (intervals_due.size() == 0) begin
        mismatches++;
        $display("%0t: interval with none expected, got led_on %0d duration_ms %0d last %0d",
                 $time, out_led_on, out_duration_ms, out_last);
      end else begin
        want_iv = intervals_due.pop_front();
        check_field("led_on", want_iv.led_on, out_led_on);
        check_field("duration_ms", want_iv.duration_ms, out_duration_ms);
        check_field("last", want_iv.last, out_last);
      end
    end
  end

  int idle_run = 0;
  initial begin
    @(posedge rst_n);
    while (idle_run < WATCHDOG_MAX) begin
      @(negedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_run = 0;
      else idle_run++;
    end
    $display("tb_morse_character_keyer failed");
    $finish;
  end

  initial begin
    logic [CHAR_W-1:0] ch;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[r]) begin
      if (DIRECTED[r].typed) begin
        for (int k = 0; k < DIRECTED[r].typed_cnt; k++)
          intervals_due.push_back(DIRECTED[r].intervals[k]);
      end else begin
        predict_intervals(DIRECTED[r].ch);
      end
      send_char(DIRECTED[r].ch);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_and_settle();
      if (p == 0) begin
        program_timing(DUR_W'(DUR_MAX), DUR_W'(DUR_MAX), DUR_W'(DUR_MAX), DUR_W'(DUR_MAX));
      end else if (p == 1) begin
        // shortest on times, zero-length gaps
        program_timing(DUR_W'(1), DUR_W'(1), '0, '0);
      end else begin
        program_timing(random_duration(1), random_duration(1), random_duration(0),
                       random_duration(0));
      end
      quiet_mode = (p == NUM_PHASES - 1);
      repeat (PHASE_ITEMS) begin
        ch = random_char();
        predict_intervals(ch);
        send_char(ch);
      end
    end

    drain_and_settle();
    if (mismatches == 0) begin
      $display("tb_morse_character_keyer passed");
    end else begin
      $display("tb_morse_character_keyer failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
